// ----- rtl/ames_pkg.sv -----
// ----------------------------------------------------------------------------
// ames_pkg: adjacency matrix edge store definitions
// Op codes, status codes, register indexes and the sequencer microprogram.
// ----------------------------------------------------------------------------
package ames_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_DEGREE = 3'd3,
    OP_LOOKUP = 3'd4,
    OP_LIST   = 3'd5
  } op_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_RANGE  = 2'd1;
  localparam status_t ST_NOEDGE = 2'd2;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DIRECTED = 1'd0;
  localparam cfg_idx_t CFG_VCOUNT   = 1'd1;

  localparam int         VCOUNT_W     = 7;
  localparam int         WEIGHT_W     = 16;
  localparam int         VERTEX_W     = 6;
  localparam logic [6:0] VCOUNT_RESET = 7'd64;

  typedef logic signed [WEIGHT_W-1:0] weight_t;

  // address select of the weight memory
  typedef enum logic [2:0] {
    AD_SD,
    AD_DS,
    AD_SI,
    AD_IS,
    AD_WIPE
  } asel_t;

  typedef enum logic [0:0] {
    WD_ZERO,
    WD_EDGE
  } wsel_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_COUNT,
    ACT_LIST
  } act_t;

  typedef enum logic [2:0] {
    OS_NONE,
    OS_RANGE,
    OS_OK,
    OS_NOEDGE,
    OS_DEG,
    OS_WEIGHT,
    OS_LIST,
    OS_FINAL
  } osel_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_DIRECTED,
    J_RD_ZERO,
    J_RD_NOTPOS,
    J_MORE,
    J_WIPE,
    J_END
  } jcond_t;

  typedef logic [4:0] uaddr_t;

  localparam uaddr_t S_RANGE = 5'd0;
  localparam uaddr_t S_ADD0  = 5'd1;
  localparam uaddr_t S_ADD1  = 5'd2;
  localparam uaddr_t S_OK    = 5'd3;
  localparam uaddr_t S_REM0  = 5'd4;
  localparam uaddr_t S_REM1  = 5'd5;
  localparam uaddr_t S_REM2  = 5'd6;
  localparam uaddr_t S_REM3  = 5'd7;
  localparam uaddr_t S_LOOK0 = 5'd8;
  localparam uaddr_t S_LOOK1 = 5'd9;
  localparam uaddr_t S_LOOK2 = 5'd10;
  localparam uaddr_t S_NOE   = 5'd11;
  localparam uaddr_t S_CLR0  = 5'd12;
  localparam uaddr_t S_CLR1  = 5'd13;
  localparam uaddr_t S_CLR2  = 5'd14;
  localparam uaddr_t S_DEG0  = 5'd15;
  localparam uaddr_t S_DEG1  = 5'd16;
  localparam uaddr_t S_DEG2  = 5'd17;
  localparam uaddr_t S_LST0  = 5'd18;
  localparam uaddr_t S_LST1  = 5'd19;
  localparam uaddr_t S_LST2  = 5'd20;
  localparam uaddr_t S_WIPE  = 5'd21;

  typedef struct packed {
    asel_t  asel;
    logic   we;
    wsel_t  wsel;
    logic   re;
    act_t   act;
    logic   inc;
    osel_t  osel;
    jcond_t jc;
    uaddr_t tgt;
  } ucw_t;

  localparam ucw_t UCW_NOP = '{asel: AD_SD, we: 1'b0, wsel: WD_ZERO, re: 1'b0,
                               act: ACT_NONE, inc: 1'b0, osel: OS_NONE,
                               jc: J_END, tgt: S_RANGE};

  function automatic ucw_t ucode(uaddr_t a);
    ucw_t w;
    w = UCW_NOP;
    case (a)
      S_RANGE: begin
        w.osel = OS_RANGE;
      end
      S_ADD0: begin
        w.asel = AD_SD; w.we = 1'b1; w.wsel = WD_EDGE;
        w.jc = J_DIRECTED; w.tgt = S_OK;
      end
      S_ADD1: begin
        w.asel = AD_DS; w.we = 1'b1; w.wsel = WD_EDGE; w.jc = J_NEXT;
      end
      S_OK: begin
        w.osel = OS_OK;
      end
      S_REM0: begin
        w.asel = AD_SD; w.re = 1'b1; w.jc = J_NEXT;
      end
      S_REM1: begin
        w.jc = J_RD_ZERO; w.tgt = S_NOE;
      end
      S_REM2: begin
        w.asel = AD_SD; w.we = 1'b1; w.jc = J_DIRECTED; w.tgt = S_OK;
      end
      S_REM3: begin
        w.asel = AD_DS; w.we = 1'b1; w.jc = J_ALWAYS; w.tgt = S_OK;
      end
      S_LOOK0: begin
        w.asel = AD_SD; w.re = 1'b1; w.jc = J_NEXT;
      end
      S_LOOK1: begin
        w.jc = J_RD_NOTPOS; w.tgt = S_NOE;
      end
      S_LOOK2: begin
        w.osel = OS_WEIGHT;
      end
      S_NOE: begin
        w.osel = OS_NOEDGE;
      end
      S_CLR0: begin
        w.asel = AD_SI; w.we = 1'b1; w.jc = J_NEXT;
      end
      S_CLR1: begin
        w.asel = AD_IS; w.we = 1'b1; w.inc = 1'b1; w.jc = J_MORE; w.tgt = S_CLR0;
      end
      S_CLR2: begin
        w.osel = OS_OK;
      end
      S_DEG0: begin
        w.asel = AD_SI; w.re = 1'b1; w.jc = J_NEXT;
      end
      S_DEG1: begin
        w.act = ACT_COUNT; w.inc = 1'b1; w.jc = J_MORE; w.tgt = S_DEG0;
      end
      S_DEG2: begin
        w.osel = OS_DEG;
      end
      S_LST0: begin
        w.asel = AD_SI; w.re = 1'b1; w.jc = J_NEXT;
      end
      S_LST1: begin
        w.act = ACT_LIST; w.osel = OS_LIST; w.inc = 1'b1;
        w.jc = J_MORE; w.tgt = S_LST0;
      end
      S_LST2: begin
        w.osel = OS_FINAL;
      end
      S_WIPE: begin
        w.asel = AD_WIPE; w.we = 1'b1; w.jc = J_WIPE; w.tgt = S_WIPE;
      end
      default: begin
        w = UCW_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/adjacency_matrix_edge_store.sv -----
// ----------------------------------------------------------------------------
// adjacency_matrix_edge_store: graph weight matrix with a microcoded sequencer
// The next item is taken at the edge that takes the last result beat; row and
// column walks visit their entries in turn through the single memory port.
// Reset and each vertex_count write run a clearing pass over all DEPTH entries
// with busy high; results cannot be stalled.
// ----------------------------------------------------------------------------
module adjacency_matrix_edge_store #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                in_op,
  input  logic [5:0]                in_src_vertex,
  input  logic [5:0]                in_dst_vertex,
  input  logic signed [15:0]        in_edge_weight,

  output logic                      out_valid,
  output ames_pkg::status_t         out_status,
  output logic [6:0]                out_result_value,
  output ames_pkg::weight_t         out_result_weight,
  output logic                      out_last,

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  ames_pkg::cfg_idx_t        cfg_index,
  input  logic [6:0]                cfg_wdata
);

  import ames_pkg::*;

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = (VW + 1 > VCOUNT_W) ? VW + 1 : VCOUNT_W;
  localparam int DW    = VW + 1;

  // weight memory
  logic [WEIGHT_W-1:0] weight_store_r [DEPTH];
  logic [WEIGHT_W-1:0] rdata_r;
  logic [AW-1:0]       mem_addr;
  logic [WEIGHT_W-1:0] mem_wdata;
  logic                mem_we;
  logic                mem_re;

  // sequencer and datapath registers
  logic              busy_r, busy_nxt;
  uaddr_t            upc_r, upc_nxt;
  logic [VW-1:0]     s_r, s_nxt;
  logic [VW-1:0]     d_r, d_nxt;
  logic [WEIGHT_W-1:0] w_r, w_nxt;
  logic [VW-1:0]     i_r, i_nxt;
  logic [DW-1:0]     deg_r, deg_nxt;
  logic [VW-1:0]     pend_r, pend_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [AW-1:0]     wipe_r, wipe_nxt;
  logic              directed_r, directed_nxt;
  logic [VCOUNT_W-1:0] vcount_r, vcount_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [6:0]        out_value_r, out_value_nxt;
  logic [WEIGHT_W-1:0] out_weight_r, out_weight_nxt;
  logic              out_last_r, out_last_nxt;

  ucw_t              uw;
  logic [NW-1:0]     n_eff;
  logic              src_bad;
  logic              dst_bad;
  uaddr_t            entry;
  logic              rd_zero;
  logic              rd_pos;
  logic              i_last;
  logic              wipe_last;
  logic [6:0]        deg_sat;

  assign uw        = ucode(upc_r);
  assign rd_zero   = (rdata_r == '0);
  assign rd_pos    = !rd_zero && !rdata_r[WEIGHT_W-1];
  assign i_last    = (i_r == VW'(MAX_VERTICES - 1));
  assign wipe_last = &wipe_r;
  assign deg_sat   = (int'(deg_r) > 127) ? 7'd127 : 7'(deg_r);

  // item decode and range check
  always_comb begin
    n_eff   = (NW'(vcount_r) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcount_r);
    src_bad = (NW'(in_src_vertex) >= n_eff);
    dst_bad = (NW'(in_dst_vertex) >= n_eff);
    case (op_t'(in_op))
      OP_ADD:    entry = (src_bad || dst_bad) ? S_RANGE : S_ADD0;
      OP_REMOVE: entry = (src_bad || dst_bad) ? S_RANGE : S_REM0;
      OP_CLEAR:  entry = src_bad ? S_RANGE : S_CLR0;
      OP_DEGREE: entry = src_bad ? S_RANGE : S_DEG0;
      OP_LOOKUP: entry = (src_bad || dst_bad) ? S_RANGE : S_LOOK0;
      OP_LIST:   entry = src_bad ? S_RANGE : S_LST0;
      default:   entry = S_RANGE;
    endcase
  end

  // datapath driven by the control word
  always_comb begin
    case (uw.asel)
      AD_SD:   mem_addr = {s_r, d_r};
      AD_DS:   mem_addr = {d_r, s_r};
      AD_SI:   mem_addr = {s_r, i_r};
      AD_IS:   mem_addr = {i_r, s_r};
      AD_WIPE: mem_addr = wipe_r;
      default: mem_addr = wipe_r;
    endcase
    mem_wdata = (uw.wsel == WD_EDGE) ? w_r : '0;
    mem_we    = busy_r && uw.we;
    mem_re    = busy_r && uw.re;
  end

  always_comb begin
    busy_nxt       = busy_r;
    upc_nxt        = upc_r;
    s_nxt          = s_r;
    d_nxt          = d_r;
    w_nxt          = w_r;
    i_nxt          = i_r;
    deg_nxt        = deg_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    wipe_nxt       = wipe_r;
    directed_nxt   = directed_r;
    vcount_nxt     = vcount_r;

    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_value_nxt  = '0;
    out_weight_nxt = '0;
    out_last_nxt   = 1'b1;

    if (!busy_r) begin
      if (start) begin
        s_nxt          = VW'(in_src_vertex);
        d_nxt          = VW'(in_dst_vertex);
        w_nxt          = in_edge_weight;
        i_nxt          = '0;
        deg_nxt        = '0;
        pend_valid_nxt = 1'b0;
        upc_nxt        = entry;
        busy_nxt       = 1'b1;
      end
    end else begin
      // step counter and jumps
      case (uw.jc)
        J_NEXT:      upc_nxt = upc_r + 5'd1;
        J_ALWAYS:    upc_nxt = uw.tgt;
        J_DIRECTED:  upc_nxt = directed_r ? uw.tgt : upc_r + 5'd1;
        J_RD_ZERO:   upc_nxt = rd_zero ? uw.tgt : upc_r + 5'd1;
        J_RD_NOTPOS: upc_nxt = !rd_pos ? uw.tgt : upc_r + 5'd1;
        J_MORE:      upc_nxt = !i_last ? uw.tgt : upc_r + 5'd1;
        J_WIPE: begin
          wipe_nxt = wipe_r + 1'b1;
          if (wipe_last) begin
            busy_nxt = 1'b0;
          end else begin
            upc_nxt = uw.tgt;
          end
        end
        J_END:       busy_nxt = 1'b0;
        default:     busy_nxt = 1'b0;
      endcase

      if (uw.inc) begin
        i_nxt = i_r + 1'b1;
      end

      case (uw.act)
        ACT_COUNT: begin
          if (!rd_zero) begin
            deg_nxt = deg_r + 1'b1;
          end
        end
        ACT_LIST: begin
          if (rd_pos) begin
            pend_nxt       = i_r;
            pend_valid_nxt = 1'b1;
          end
        end
        default: ;
      endcase

      // result beat
      case (uw.osel)
        OS_RANGE: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_RANGE;
        end
        OS_OK: begin
          out_valid_nxt = 1'b1;
        end
        OS_NOEDGE: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOEDGE;
        end
        OS_DEG: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = deg_sat;
        end
        OS_WEIGHT: begin
          out_valid_nxt  = 1'b1;
          out_weight_nxt = rdata_r;
        end
        OS_LIST: begin
          // a new neighbor releases the held one, which is then not last
          if (rd_pos && pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = 7'(pend_r);
            out_last_nxt  = 1'b0;
          end
        end
        OS_FINAL: begin
          out_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_value_nxt = 7'(pend_r);
          end else begin
            out_status_nxt = ST_NOEDGE;
          end
        end
        default: ;
      endcase
    end

    // register writes
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIRECTED: directed_nxt = cfg_wdata[0];
        CFG_VCOUNT: begin
          vcount_nxt = cfg_wdata;
          busy_nxt   = 1'b1;
          upc_nxt    = S_WIPE;
          wipe_nxt   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      weight_store_r[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= weight_store_r[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      upc_r        <= S_WIPE;
      wipe_r       <= '0;
      directed_r   <= 1'b0;
      vcount_r     <= VCOUNT_RESET;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      upc_r        <= upc_nxt;
      wipe_r       <= wipe_nxt;
      directed_r   <= directed_nxt;
      vcount_r     <= vcount_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r          <= s_nxt;
    d_r          <= d_nxt;
    w_r          <= w_nxt;
    i_r          <= i_nxt;
    deg_r        <= deg_nxt;
    pend_r       <= pend_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_weight_r <= out_weight_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy              = busy_r;
  assign cfg_ready         = !busy_r;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_value  = out_value_r;
  assign out_result_weight = $signed(out_weight_r);
  assign out_last          = out_last_r;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for adjacency_matrix_edge_store
// Runs a short table of graph operations at the reset settings, then random
// phases under several directed / vertex_count settings with random idle
// bursts. A behavioral copy of the weight matrix predicts each result beat but
// for typed table rows, which carry their own; every strobed beat is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ames_pkg::*;

  localparam int NV          = 64;
  localparam int LIST_CAP    = 64;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 200;
  localparam int NPHASES     = 8;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    status_t    status;
    logic [6:0] value;
    weight_t    weight;
    logic       last;
  } result_beat_t;

  typedef struct {
    logic [2:0]   op;
    logic [5:0]   src;
    logic [5:0]   dst;
    weight_t      w;
    logic         typed;
    result_beat_t want;
  } op_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [2:0]        in_op;
  logic [5:0]        in_src_vertex;
  logic [5:0]        in_dst_vertex;
  logic signed [15:0] in_edge_weight;
  logic              out_valid;
  status_t           out_status;
  logic [6:0]        out_result_value;
  weight_t           out_result_weight;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  cfg_idx_t          cfg_index;
  logic [6:0]        cfg_wdata;

  adjacency_matrix_edge_store #(.MAX_VERTICES(NV)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_src_vertex    (in_src_vertex),
    .in_dst_vertex    (in_dst_vertex),
    .in_edge_weight   (in_edge_weight),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_result_weight(out_result_weight),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  logic [15:0]  graph_weights [NV][NV];
  logic         graph_directed;
  logic [6:0]   graph_vcount;
  result_beat_t expected_results [$];
  result_beat_t op_results [$];
  op_row_t      op_table [$];

  logic         cur_typed;
  result_beat_t cur_want;
  int           errors;
  int           accepted_ops;
  int           accepted_writes;
  int           idle_cycles;

  int ph_directed [NPHASES] = '{1, 0, 1, 0, 1, 0, 1, 0};
  int ph_vcount   [NPHASES] = '{64, 1, 8, 5, 0, 127, 3, 16};
  int ph_ops      [NPHASES] = '{30, 30, 50, 50, 20, 50, 40, 50};

  always #10 clk = ~clk;

  function automatic int live_vertices();
    return (graph_vcount > NV) ? NV : int'(graph_vcount);
  endfunction

  function automatic logic [5:0] pick_vertex();
    int n;
    n = live_vertices();
    if (n == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, n - 1));
  endfunction

  task automatic wipe_graph();
    foreach (graph_weights[r, c]) graph_weights[r][c] = '0;
  endtask

  task automatic apply_graph_op(input logic [2:0] op, input logic [5:0] s,
                                input logic [5:0] d, input weight_t w);
    int n;
    int deg;
    logic need_dst;
    logic [15:0] v;
    result_beat_t b;
    n = live_vertices();
    need_dst = (op == OP_ADD) || (op == OP_REMOVE) || (op == OP_LOOKUP);
    b = '0;
    b.status = ST_OK;
    b.last = 1'b1;
    op_results.delete();
    if (op > OP_LIST || s >= n || (need_dst && d >= n)) begin
      b.status = ST_RANGE;
      op_results = {op_results, b};
    end else begin
      case (op)
        OP_ADD: begin
          graph_weights[s][d] = w;
          if (!graph_directed) graph_weights[d][s] = w;
          op_results = {op_results, b};
        end
        OP_REMOVE: begin
          if (graph_weights[s][d] == 16'd0) begin
            b.status = ST_NOEDGE;
          end else begin
            graph_weights[s][d] = '0;
            if (!graph_directed) graph_weights[d][s] = '0;
          end
          op_results = {op_results, b};
        end
        OP_CLEAR: begin
          for (int i = 0; i < n; i++) begin
            graph_weights[s][i] = '0;
            graph_weights[i][s] = '0;
          end
          op_results = {op_results, b};
        end
        OP_DEGREE: begin
          deg = 0;
          for (int i = 0; i < n; i++) if (graph_weights[s][i] != 16'd0) deg++;
          if (deg > 127) deg = 127;
          b.value = deg[6:0];
          op_results = {op_results, b};
        end
        OP_LOOKUP: begin
          v = graph_weights[s][d];
          if (v != 16'd0 && !v[15]) b.weight = v;
          else b.status = ST_NOEDGE;
          op_results = {op_results, b};
        end
        default: begin
          for (int i = 0; i < n && op_results.size() < LIST_CAP; i++) begin
            v = graph_weights[s][i];
            if (v != 16'd0 && !v[15]) begin
              b.value = i[6:0];
              b.last = 1'b0;
              op_results = {op_results, b};
            end
          end
          if (op_results.size() == 0) begin
            b.status = ST_NOEDGE;
            b.value = '0;
            b.last = 1'b1;
            op_results = {op_results, b};
          end else begin
            op_results[op_results.size() - 1].last = 1'b1;
          end
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_beat_t want;
    logic active;
    active = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        active = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d value %0d weight %0h last %0d",
                 out_status, out_result_value, out_result_weight, out_last);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 16'(want.status), 16'(out_status));
          check_field("result_value", 16'(want.value), 16'(out_result_value));
          check_field("result_weight", want.weight, out_result_weight);
          check_field("last", 16'(want.last), 16'(out_last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        active = 1'b1;
        accepted_writes++;
        if (cfg_index == CFG_DIRECTED) begin
          graph_directed = cfg_wdata[0];
        end else begin
          graph_vcount = cfg_wdata;
          wipe_graph();
        end
      end
      if (start && !busy) begin
        active = 1'b1;
        accepted_ops++;
        apply_graph_op(in_op, in_src_vertex, in_dst_vertex, in_edge_weight);
        if (cur_typed) expected_results = {expected_results, cur_want};
        else foreach (op_results[k]) expected_results = {expected_results, op_results[k]};
      end
    end
    if (active) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_op(input logic [2:0] op, input logic [5:0] s, input logic [5:0] d,
                         input weight_t w, input logic typed, input result_beat_t want,
                         input logic may_idle);
    int seen;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    seen = accepted_ops;
    start          <= 1'b1;
    in_op          <= op;
    in_src_vertex  <= s;
    in_dst_vertex  <= d;
    in_edge_weight <= w;
    cur_typed      <= typed;
    cur_want       <= want;
    do @(negedge clk); while (accepted_ops == seen);
  endtask

  task automatic send_random_op(input logic may_idle);
    int r;
    logic [2:0] op;
    weight_t w;
    r = $urandom_range(0, 99);
    if (r < 35) op = OP_ADD;
    else if (r < 45) op = OP_REMOVE;
    else if (r < 52) op = OP_CLEAR;
    else if (r < 62) op = OP_DEGREE;
    else if (r < 80) op = OP_LOOKUP;
    else if (r < 95) op = OP_LIST;
    else op = ($urandom_range(0, 1) == 0) ? OP_RSVD6 : OP_RSVD7;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = 16'sh7fff;
      2: w = 16'sh8000;
      3, 4: w = {1'b1, 15'($urandom)};
      default: w = weight_t'($urandom_range(1, 32767));
    endcase
    send_op(op, pick_vertex(), pick_vertex(), w, 1'b0, '0, may_idle);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [6:0] data);
    int seen;
    seen = accepted_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(negedge clk); while (accepted_writes == seen);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic add_row(input logic [2:0] op, input logic [5:0] s, input logic [5:0] d,
                         input weight_t w, input logic typed, input status_t st,
                         input logic [6:0] value);
    op_row_t row;
    row.op = op;
    row.src = s;
    row.dst = d;
    row.w = w;
    row.typed = typed;
    row.want = '0;
    row.want.status = st;
    row.want.value = value;
    row.want.last = 1'b1;
    op_table = {op_table, row};
  endtask

  initial begin : stimulus
    logic [5:0] row_v;
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_op           = '0;
    in_src_vertex   = '0;
    in_dst_vertex   = '0;
    in_edge_weight  = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_DIRECTED;
    cfg_wdata       = '0;
    cur_typed       = 1'b0;
    cur_want        = '0;
    errors          = 0;
    accepted_ops    = 0;
    accepted_writes = 0;
    idle_cycles     = 0;
    graph_directed  = 1'b0;
    graph_vcount    = VCOUNT_RESET;
    wipe_graph();

    // reset settings: undirected, 64 vertices
    add_row(OP_LOOKUP, 6'd0,  6'd0,  16'sh0000, 1'b1, ST_NOEDGE, 7'd0);
    add_row(OP_DEGREE, 6'd63, 6'd0,  16'sh0000, 1'b1, ST_OK,     7'd0);
    add_row(OP_LIST,   6'd0,  6'd63, 16'sh0000, 1'b1, ST_NOEDGE, 7'd0);
    add_row(OP_REMOVE, 6'd5,  6'd6,  16'sh0000, 1'b1, ST_NOEDGE, 7'd0);
    add_row(OP_RSVD6,  6'd0,  6'd0,  16'sh0000, 1'b1, ST_RANGE,  7'd0);
    add_row(OP_RSVD7,  6'd63, 6'd63, 16'shffff, 1'b1, ST_RANGE,  7'd0);
    add_row(OP_ADD,    6'd0,  6'd63, 16'sh7fff, 1'b1, ST_OK,     7'd0);
    add_row(OP_LOOKUP, 6'd63, 6'd0,  16'sh0000, 1'b0, ST_OK,     7'd0);
    add_row(OP_ADD,    6'd63, 6'd63, 16'sh8000, 1'b1, ST_OK,     7'd0);
    add_row(OP_LOOKUP, 6'd63, 6'd63, 16'sh0000, 1'b0, ST_OK,     7'd0);
    add_row(OP_DEGREE, 6'd63, 6'd0,  16'sh0000, 1'b0, ST_OK,     7'd0);
    add_row(OP_LIST,   6'd63, 6'd0,  16'sh0000, 1'b0, ST_OK,     7'd0);
    add_row(OP_ADD,    6'd1,  6'd2,  16'sh0000, 1'b1, ST_OK,     7'd0);
    add_row(OP_DEGREE, 6'd1,  6'd0,  16'sh0000, 1'b0, ST_OK,     7'd0);
    add_row(OP_REMOVE, 6'd1,  6'd2,  16'sh0000, 1'b0, ST_OK,     7'd0);
    add_row(OP_ADD,    6'd1,  6'd2,  16'sh0100, 1'b0, ST_OK,     7'd0);
    add_row(OP_ADD,    6'd1,  6'd3,  16'sh0001, 1'b0, ST_OK,     7'd0);
    add_row(OP_LIST,   6'd1,  6'd0,  16'sh0000, 1'b0, ST_OK,     7'd0);
    add_row(OP_REMOVE, 6'd2,  6'd1,  16'sh0000, 1'b0, ST_OK,     7'd0);
    add_row(OP_LOOKUP, 6'd1,  6'd2,  16'sh0000, 1'b0, ST_OK,     7'd0);
    add_row(OP_CLEAR,  6'd63, 6'd0,  16'sh0000, 1'b0, ST_OK,     7'd0);
    add_row(OP_LOOKUP, 6'd0,  6'd63, 16'sh0000, 1'b0, ST_OK,     7'd0);
    add_row(OP_LIST,   6'd0,  6'd0,  16'sh0000, 1'b0, ST_OK,     7'd0);
    add_row(OP_DEGREE, 6'd0,  6'd0,  16'sh0000, 1'b0, ST_OK,     7'd0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (op_table[k]) begin
      send_op(op_table[k].op, op_table[k].src, op_table[k].dst, op_table[k].w,
              op_table[k].typed, op_table[k].want, 1'b1);
    end

    for (int p = 0; p < NPHASES; p++) begin
      drain();
      write_reg(CFG_DIRECTED, 7'(ph_directed[p]));
      write_reg(CFG_VCOUNT, 7'(ph_vcount[p]));
      if (p == 0) begin
        // fill one row completely so the list hits its cap
        row_v = 6'($urandom_range(0, 63));
        for (int c = 0; c < NV; c++) begin
          send_op(OP_ADD, row_v, 6'(c), weight_t'($urandom_range(1, 32767)), 1'b0, '0, 1'b1);
        end
        send_op(OP_LIST, row_v, pick_vertex(), '0, 1'b0, '0, 1'b1);
        send_op(OP_DEGREE, row_v, pick_vertex(), '0, 1'b0, '0, 1'b1);
      end
      repeat (ph_ops[p]) send_random_op(p != NPHASES - 1);
    end

    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ames_pkg.sv
rtl/adjacency_matrix_edge_store.sv
test/tb_top.sv
